>>> sv/keyed_quantity_accumulator_table_top_macros.svh
// Assertion macros for the keyed quantity accumulator table checker.
// Uses clk_i and rst_ni from the scope that expands the macro.
`ifndef KEYED_QUANTITY_ACCUMULATOR_TABLE_TOP_MACROS_SVH
`define KEYED_QUANTITY_ACCUMULATOR_TABLE_TOP_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define KQAT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define KQAT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> sv/kqat_pkg.sv
// Shared types and constants of the keyed quantity accumulator table.
// No dependencies; every other file but kqat_ram and the macros header imports this package.
`default_nettype none

package kqat_pkg;

  // Slot count of the hashed store; must be a power of two (home slot = key low bits).
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned DELTA_W  = 32;
  localparam int unsigned QTY_W    = 48;
  localparam int unsigned TOTAL_W  = 63;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 112;

  localparam logic [QTY_W-1:0]   QTY_MAX   = {QTY_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic [STATUS_W-1:0] STAT_UPDATED  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_INSERTED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_IGNORED  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [QTY_W-1:0] qty;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  // Request to the running total unit.
  typedef struct packed {
    logic             en;
    logic             inc;
    logic [QTY_W-1:0] amount;
  } tot_req_t;

endpackage

`default_nettype wire

>>> sv/kqat_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module kqat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/kqat_total.sv
// Saturating running total of all stored quantities.
// Depends on kqat_pkg.
`default_nettype none

module kqat_total
  import kqat_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tot_req_t           req_i,
  output logic      [TOTAL_W-1:0] sum_o
);

  logic [TOTAL_W-1:0] sum_q, sum_d;
  logic [TOTAL_W:0]   add_w;
  logic [TOTAL_W-1:0] amt_w;

  always_comb begin
    amt_w = {{(TOTAL_W-QTY_W){1'b0}}, req_i.amount};
    add_w = {1'b0, sum_q} + {1'b0, amt_w};
    sum_d = sum_q;
    if (req_i.en) begin
      if (req_i.inc) begin
        sum_d = add_w[TOTAL_W] ? TOTAL_MAX : add_w[TOTAL_W-1:0];
      end else begin
        // floor at zero
        sum_d = (amt_w > sum_q) ? '0 : sum_q - amt_w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

>>> sv/keyed_quantity_accumulator_table_top.sv
// Channel   Dir  tdata (low bit up)                          tuser
// s_axis    in   key[31:0], delta[63:32]                     -
// m_axis    out  entry_quantity[47:0], running_total[110:48] status[1:0]
//
// One item at a time. An update passes through the states CHECK, CALC, DIFF, TOTAL and
// OUT, an insert through CHECK, TOTAL and OUT and an ignored or full item through CHECK
// and OUT; CHECK repeats for each extra slot probed (one slot RAM read per cycle,
// registered read data). s_axis_tready is high again from the cycle the result is
// presented. After reset a clearing pass writes every slot invalid with s_axis_tready
// low. The next item is taken while a result waits; the block then holds before its
// own result until the previous one has been transferred.
// Depends on kqat_pkg, kqat_ram, kqat_total.
`default_nettype none

module keyed_quantity_accumulator_table_top
  import kqat_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // key, delta
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,   // entry_quantity, running_total, pad
  output logic      [STATUS_W-1:0]    m_axis_tuser    // status
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_CALC  = 3'd3;
  localparam logic [2:0] ST_DIFF  = 3'd4;
  localparam logic [2:0] ST_TOTAL = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  logic [2:0]          state_q, state_d;
  logic [IDX_W-1:0]    clr_q, clr_d;
  logic [IDX_W-1:0]    probe_q, probe_d;
  logic [IDX_W-1:0]    cnt_q, cnt_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [DELTA_W-1:0]  mag_q, mag_d;
  logic                neg_q, neg_d;
  logic                pos_q, pos_d;
  logic [QTY_W-1:0]    qty_q, qty_d;
  logic [QTY_W-1:0]    diff_q, diff_d;
  logic                inc_q, inc_d;
  logic [STATUS_W-1:0] stat_q, stat_d;
  logic                mvalid_q, mvalid_d;
  logic [QTY_W-1:0]    oqty_q, oqty_d;
  logic [TOTAL_W-1:0]  otot_q, otot_d;
  logic [STATUS_W-1:0] ostat_q, ostat_d;

  logic                accept;
  logic [DELTA_W-1:0]  in_delta;
  logic                re;
  logic [IDX_W-1:0]    raddr;
  logic                we;
  logic [IDX_W-1:0]    waddr;
  slot_t               wslot;
  logic [SLOT_W-1:0]   rdata;
  slot_t               rslot;
  logic [IDX_W-1:0]    probe_nxt;
  logic [QTY_W-1:0]    mag48;
  logic [QTY_W:0]      qsum;
  tot_req_t            tot_req;
  logic [TOTAL_W-1:0]  total;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign in_delta  = s_axis_tdata[KEY_W +: DELTA_W];
  assign rslot     = slot_t'(rdata);
  assign probe_nxt = (probe_q == LAST_IDX) ? '0 : probe_q + 1'b1;
  assign mag48     = {{(QTY_W-DELTA_W){1'b0}}, mag_q};
  assign qsum      = {1'b0, rslot.qty} + {1'b0, mag48};

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    probe_d  = probe_q;
    cnt_d    = cnt_q;
    key_d    = key_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    pos_d    = pos_q;
    qty_d    = qty_q;
    diff_d   = diff_q;
    inc_d    = inc_q;
    stat_d   = stat_q;
    mvalid_d = mvalid_q;
    oqty_d   = oqty_q;
    otot_d   = otot_q;
    ostat_d  = ostat_q;
    re       = 1'b0;
    raddr    = probe_nxt;
    we       = 1'b0;
    waddr    = probe_q;
    wslot    = '0;
    tot_req  = '0;
    s_axis_tready = (state_q == ST_IDLE);

    if (mvalid_q && m_axis_tready) begin
      mvalid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        raddr = s_axis_tdata[IDX_W-1:0];
        if (accept) begin
          re      = 1'b1;
          probe_d = s_axis_tdata[IDX_W-1:0];
          cnt_d   = '0;
          key_d   = s_axis_tdata[KEY_W-1:0];
          neg_d   = in_delta[DELTA_W-1];
          pos_d   = !in_delta[DELTA_W-1] && (in_delta != '0);
          mag_d   = in_delta[DELTA_W-1] ? (~in_delta + 1'b1) : in_delta;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!rslot.valid) begin
          if (pos_q) begin
            // insert at the empty slot the probe stopped on
            we      = 1'b1;
            wslot   = '{valid: 1'b1, key: key_q, qty: mag48};
            qty_d   = mag48;
            diff_d  = mag48;
            inc_d   = 1'b1;
            stat_d  = STAT_INSERTED;
            state_d = ST_TOTAL;
          end else begin
            qty_d   = '0;
            stat_d  = STAT_IGNORED;
            state_d = ST_OUT;
          end
        end else if (rslot.key == key_q) begin
          stat_d  = STAT_UPDATED;
          state_d = ST_CALC;
        end else if (cnt_q == LAST_IDX) begin
          qty_d   = '0;
          stat_d  = pos_q ? STAT_FULL : STAT_IGNORED;
          state_d = ST_OUT;
        end else begin
          // advance to the next slot
          re      = 1'b1;
          probe_d = probe_nxt;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      ST_CALC: begin
        if (neg_q) begin
          qty_d = (mag48 >= rslot.qty) ? '0 : rslot.qty - mag48;
        end else begin
          qty_d = qsum[QTY_W] ? QTY_MAX : qsum[QTY_W-1:0];
        end
        we      = 1'b1;
        wslot   = '{valid: 1'b1, key: key_q, qty: qty_d};
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        inc_d   = !neg_q;
        diff_d  = neg_q ? rslot.qty - qty_q : qty_q - rslot.qty;
        state_d = ST_TOTAL;
      end
      ST_TOTAL: begin
        tot_req = '{en: 1'b1, inc: inc_q, amount: diff_q};
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d = 1'b1;
          oqty_d   = qty_q;
          otot_d   = total;
          ostat_d  = stat_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_q <= probe_d;
    cnt_q   <= cnt_d;
    key_q   <= key_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    pos_q   <= pos_d;
    qty_q   <= qty_d;
    diff_q  <= diff_d;
    inc_q   <= inc_d;
    stat_q  <= stat_d;
    oqty_q  <= oqty_d;
    otot_q  <= otot_d;
    ostat_q <= ostat_d;
  end

  kqat_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wslot),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  kqat_total u_total (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tot_req),
    .sum_o  (total)
  );

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-QTY_W-TOTAL_W){1'b0}}, otot_q, oqty_q};
  assign m_axis_tuser  = ostat_q;

endmodule

`default_nettype wire

>>> sv/kqat_sva.sv
// Port-level checker for the keyed quantity accumulator table, bound to the top.
// Depends on kqat_pkg and keyed_quantity_accumulator_table_top_macros.svh.
`default_nettype none
`include "keyed_quantity_accumulator_table_top_macros.svh"

module kqat_sva
  import kqat_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // key, delta
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,   // entry_quantity, running_total, pad
  input wire logic [STATUS_W-1:0]    m_axis_tuser    // status
);

  logic             in_xfer;
  logic             out_miss;
  logic [QTY_W-1:0] out_qty;

  assign in_xfer  = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);
  assign out_miss = m_axis_tuser inside {STAT_IGNORED, STAT_FULL};
  assign out_qty  = m_axis_tdata[QTY_W-1:0];

  // The output valid register is cleared asynchronously by reset.
  `KQAT_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |=> !m_axis_tvalid, "result valid in reset")

  `KQAT_ASSERT(a_one_item_at_a_time, in_xfer |=> !s_axis_tready, "second item taken in flight")

  `KQAT_ASSERT(a_miss_has_zero_qty, m_axis_tvalid && out_miss |-> out_qty == '0, "miss with qty")

  `KQAT_ASSERT(a_insert_nonzero, m_axis_tvalid && m_axis_tuser == STAT_INSERTED |-> out_qty != '0, "insert with zero quantity")

  `KQAT_ASSERT(a_result_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind keyed_quantity_accumulator_table_top kqat_sva u_kqat_sva (.*);

`default_nettype wire

>>> bench/kqat_ledger_checker.sv
// Scoreboard for the keyed quantity accumulator table: keeps its own copy of the
// slot store and running total, predicts one result per input transfer and
// compares it with the output channel. Depends on kqat_pkg.
module kqat_ledger_checker
  import kqat_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,    // key, delta
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,    // entry_quantity, running_total, pad
  input  logic [STATUS_W-1:0]    m_axis_tuser,    // status
  output int                     fails_o,
  output int                     open_results_o
);

  typedef struct packed {
    logic [QTY_W-1:0]    qty;
    logic [TOTAL_W-1:0]  total;
    logic [STATUS_W-1:0] status;
  } reply_t;

  bit                 held    [TABLE_DEPTH];
  logic [KEY_W-1:0]   held_key[TABLE_DEPTH];
  logic [QTY_W-1:0]   held_qty[TABLE_DEPTH];
  logic [TOTAL_W-1:0] stock_total;
  reply_t             replies_q[$];
  int                 fails = 0;

  assign fails_o = fails;

  // Probe from the home slot, apply the change and return the expected result.
  task automatic book_change(input logic [KEY_W-1:0] key, input logic [DELTA_W-1:0] delta,
                             output reply_t r);
    logic [DELTA_W-1:0] mag;
    logic [63:0]        prior, next, wide_total, qty_cap, total_cap;
    int unsigned        slot, n;
    bit                 hit, hole;
    qty_cap   = {16'd0, QTY_MAX};
    total_cap = {1'b0, TOTAL_MAX};
    mag  = delta[DELTA_W-1] ? (~delta + 1'b1) : delta;
    slot = key % TABLE_DEPTH;
    n    = 0;
    while (n < TABLE_DEPTH && held[slot] && held_key[slot] != key) begin
      slot = (slot + 1) % TABLE_DEPTH;
      n++;
    end
    hit   = (n < TABLE_DEPTH) && held[slot];
    hole  = (n < TABLE_DEPTH) && !held[slot];
    prior = '0;
    next  = '0;
    if (hit) begin
      prior = {16'd0, held_qty[slot]};
      if (delta[DELTA_W-1]) begin
        next = (mag >= prior) ? 64'd0 : prior - mag;
      end else begin
        next = (mag > qty_cap - prior) ? qty_cap : prior + mag;
      end
      held_qty[slot] = next[QTY_W-1:0];
      r.status = STAT_UPDATED;
    end else if (delta[DELTA_W-1] || delta == '0) begin
      r.status = STAT_IGNORED;
    end else if (!hole) begin
      r.status = STAT_FULL;
    end else begin
      next           = {32'd0, mag};
      held[slot]     = 1'b1;
      held_key[slot] = key;
      held_qty[slot] = next[QTY_W-1:0];
      r.status       = STAT_INSERTED;
    end
    // Saturate the total on the way up, floor it at zero on the way down.
    wide_total = {1'b0, stock_total};
    if (next >= prior) begin
      wide_total = (next - prior > total_cap - wide_total) ? total_cap
                                                           : wide_total + (next - prior);
    end else begin
      wide_total = (prior - next > wide_total) ? 64'd0 : wide_total - (prior - next);
    end
    stock_total = wide_total[TOTAL_W-1:0];
    r.qty       = next[QTY_W-1:0];
    r.total     = stock_total;
  endtask

  task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
    fails++;
    $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reply_t want, got;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) held[i] = 1'b0;
      stock_total = '0;
      replies_q.delete();
      open_results_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.qty    = m_axis_tdata[QTY_W-1:0];
        got.total  = m_axis_tdata[QTY_W +: TOTAL_W];
        got.status = m_axis_tuser;
        if (replies_q.size() == 0) begin
          fails++;
          $display("%0t: result transfer expected none, got status %0d quantity %0d",
                   $time, got.status, got.qty);
        end else begin
          want = replies_q.pop_front();
          if (got.qty !== want.qty) flag("entry_quantity", 64'(want.qty), 64'(got.qty));
          if (got.total !== want.total) begin
            flag("running_total", 64'(want.total), 64'(got.total));
          end
          if (got.status !== want.status) begin
            flag("status", 64'(want.status), 64'(got.status));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        book_change(s_axis_tdata[KEY_W-1:0], s_axis_tdata[KEY_W +: DELTA_W], want);
        replies_q.push_back(want);
      end
      open_results_o <= replies_q.size();
    end
  end

endmodule

>>> bench/keyed_quantity_accumulator_table_top_tb.sv
// Testbench top for the keyed quantity accumulator table: clock, reset, input
// and output traffic and the verdict. Depends on kqat_pkg, the block and
// kqat_ledger_checker, which predicts and compares.
module keyed_quantity_accumulator_table_top_tb;
  import kqat_pkg::*;

  localparam int          STOCK_KEYS   = 48;
  localparam int          RANDOM_ITEMS = 520;
  localparam longint      CYCLE_LIMIT  = 200_000;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;

  int               fails;
  int               open_results;
  bit               calm      = 1'b0;
  int               hold_off  = 0;
  longint           cycles    = 0;
  logic [KEY_W-1:0] stock_keys[STOCK_KEYS];

  keyed_quantity_accumulator_table_top i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  kqat_ledger_checker i_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .fails_o        (fails),
    .open_results_o (open_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("keyed_quantity_accumulator_table_top_tb NOT OK");
      $finish;
    end
  end

  // Receiver: random stall before each transfer, or a long hold-off on request.
  initial begin : sink
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_off > 0) begin
        stall    = hold_off;
        hold_off = 0;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 5);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Keep tvalid high across back-to-back transfers; lower it only for a gap.
  task automatic offer(input logic [KEY_W-1:0] key, input logic [DELTA_W-1:0] delta);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {delta, key};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (open_results != 0);
  endtask

  function automatic logic [DELTA_W-1:0] pick_delta();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3, 4:    return $urandom();
      5, 6:    return ~$urandom_range(0, 4999);
      default: return $urandom_range(1, 100000);
    endcase
  endfunction

  initial begin : stimulus
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] home;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Absent key with zero or negative change: nothing stored; then two inserts.
    offer(32'd0, 32'h0000_0000);
    offer(32'd0, 32'hFFFF_FFFF);
    offer(32'd0, 32'h8000_0000);
    offer(32'd0, 32'd1);
    offer(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    // Same home slot as key 0: probe past it.
    offer(32'd1024, 32'd5);
    offer(32'd2048, 32'd7);
    offer(32'd1024, 32'd0);
    offer(32'd2048, 32'hFFFF_FFFD);
    // Drive below zero, then show the emptied entry stays stored.
    offer(32'd2048, 32'hFFFF_FF9C);
    offer(32'd2048, 32'hFFFF_FFFF);
    offer(32'd2048, 32'd9);
    offer(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    offer(32'hFFFF_FFFF, 32'h8000_0000);
    // Home slot at the top of the table: probe wraps to the bottom.
    offer(32'h0000_03FF, 32'd3);
    offer(32'h0000_03FF, 32'hFFFF_FFFF);
    offer(32'd3, 32'd0);
    offer(32'hAAAA_5555, 32'h5555_AAAA);
    offer(32'h5555_AAAA, 32'hAAAA_5555);
    offer(32'hAAAA_5555, 32'hAAAA_5555);
    drain();

    // Working set of keys, some crowded onto shared home slots.
    for (int i = 0; i < STOCK_KEYS; i++) begin
      stock_keys[i] = $urandom();
      if (i < 12) begin
        home          = IDX_W'(TABLE_DEPTH - 2 + i);
        stock_keys[i] = {stock_keys[i][KEY_W-1:IDX_W], home};
      end else if (i < 18) begin
        home          = IDX_W'(TABLE_DEPTH / 2);
        stock_keys[i] = {stock_keys[i][KEY_W-1:IDX_W], home};
      end
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150) hold_off = 300;
      calm = (i >= 150 && i < 200) || (i >= 400 && i < 460);
      if (i == 300) drain();
      key = ($urandom_range(0, 4) == 0) ? $urandom()
                                         : stock_keys[$urandom_range(0, STOCK_KEYS - 1)];
      offer(key, pick_delta());
    end
    calm = 1'b0;
    drain();

    offer(32'h1234_5678, 32'd10);
    offer(32'hFFFF_FC00, 32'h7FFF_FFFF);
    offer(32'h0000_0404, 32'hFFFF_FFFF);
    offer(32'h0000_0808, 32'h0000_0000);
    offer(32'd2048, 32'd1);
    offer(32'd0, 32'h8000_0000);
    drain();

    repeat (16) @(posedge clk_i);
    if (fails == 0 && open_results == 0) begin
      $display("keyed_quantity_accumulator_table_top_tb OK");
    end else begin
      $display("keyed_quantity_accumulator_table_top_tb NOT OK");
    end
    $finish;
  end

endmodule
